### design/tlpap_pkg.sv
// Package for the tagged, length-prefixed attribute parser.
// Holds the sizes, event and error codes and the result types used by the core, queue, top level and checker.
// Depends on nothing.
`timescale 1ns / 1ps
package tlpap_pkg;

	localparam int MAX_NAME_BYTES = 64;
	// The position counter must also hold MAX_NAME_BYTES itself.
	localparam int POS_W  = $clog2(MAX_NAME_BYTES + 1);
	localparam int ADDR_W = (MAX_NAME_BYTES > 1) ? $clog2(MAX_NAME_BYTES) : 1;

	localparam logic [2:0] EV_NAME     = 3'd0;
	localparam logic [2:0] EV_STRING   = 3'd1;
	localparam logic [2:0] EV_INTEGER  = 3'd2;
	localparam logic [2:0] EV_BOOLEAN  = 3'd3;
	localparam logic [2:0] EV_COMPLETE = 3'd4;
	localparam logic [2:0] EV_ACCEPT   = 3'd5;
	localparam logic [2:0] EV_ERROR    = 3'd6;

	localparam logic [3:0] ERR_UNEXPECTED_END = 4'd0;
	localparam logic [3:0] ERR_NON_DIGIT      = 4'd1;
	localparam logic [3:0] ERR_LEADING_ZERO   = 4'd2;
	localparam logic [3:0] ERR_TOO_LARGE      = 4'd3;
	localparam logic [3:0] ERR_LENGTH_PAST    = 4'd4;
	localparam logic [3:0] ERR_ORDER          = 4'd5;
	localparam logic [3:0] ERR_BAD_TAG        = 4'd6;
	localparam logic [3:0] ERR_BAD_BOOLEAN    = 4'd7;
	localparam logic [3:0] ERR_NAME_TOO_LONG  = 4'd8;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [63:0] payload;
		logic [3:0]  error_code;
		logic        last_result;
	} result_t;

	// Up to two results that one request produces, handed to the output queue.
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

endpackage

### design/tlpap_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the previous-name buffer. Depends on nothing.
`timescale 1ns / 1ps
module tlpap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/tlpap_core.sv
// Parser state machine: checks one byte or end marker per request and produces up to two results.
// Depends on tlpap_pkg and tlpap_ram (previous-name buffer).
`timescale 1ns / 1ps
module tlpap_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [7:0]       data_byte,
	input  logic             end_marker,
	output tlpap_pkg::push_t push
);
	import tlpap_pkg::*;

	localparam logic [2:0] PH_TAG  = 3'd0;
	localparam logic [2:0] PH_NLEN = 3'd1;
	localparam logic [2:0] PH_NAME = 3'd2;
	localparam logic [2:0] PH_SLEN = 3'd3;
	localparam logic [2:0] PH_SVAL = 3'd4;
	localparam logic [2:0] PH_INT  = 3'd5;
	localparam logic [2:0] PH_BOOL = 3'd6;

	localparam logic [1:0] TAG_S = 2'd0;
	localparam logic [1:0] TAG_I = 2'd1;
	localparam logic [1:0] TAG_B = 2'd2;
	localparam logic [1:0] TAG_X = 2'd3;

	localparam logic [1:0] CMP_EQ      = 2'd0;
	localparam logic [1:0] CMP_LESS    = 2'd1;
	localparam logic [1:0] CMP_GREATER = 2'd2;

	localparam logic [1:0] DC_NONE = 2'd0;
	localparam logic [1:0] DC_ONE  = 2'd1;
	localparam logic [1:0] DC_MORE = 2'd2;

	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [POS_W-1:0] MAX_POS   = POS_W'(MAX_NAME_BYTES);
	localparam logic [63:0]      MAX_LEN64 = 64'(MAX_NAME_BYTES);

	function automatic result_t make_res(logic [2:0] ev, logic [63:0] pay, logic [3:0] code);
		result_t r;
		r.event_res   = ev;
		r.payload     = pay;
		r.error_code  = code;
		r.last_result = 1'b0;
		return r;
	endfunction

	logic [2:0]       phase_q, phase_d;
	logic [1:0]       tag_q, tag_d;
	logic [63:0]      acc_q, acc_d;
	logic [1:0]       dcls_q, dcls_d;
	logic [63:0]      rem_q, rem_d;
	logic [POS_W-1:0] prev_len_q, prev_len_d;
	logic             have_prev_q, have_prev_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [1:0]       cmp_q, cmp_d;
	logic             err_q, err_d;

	logic             ram_we;
	logic [7:0]       prev_byte;

	tlpap_ram #(
		.WIDTH(8),
		.DEPTH(MAX_NAME_BYTES)
	) u_name_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pos_q[ADDR_W-1:0]),
		.wdata(data_byte),
		.raddr(pos_d[ADDR_W-1:0]),
		.rdata(prev_byte)
	);

	always_comb begin
		logic             is_digit;
		logic [67:0]      acc10;
		logic [7:0]       term;
		logic             dec_err;
		logic [3:0]       dec_code;
		logic             dec_done;
		logic [1:0]       cmp_n;
		logic [POS_W-1:0] pos_n;
		logic             fin_req;
		logic [1:0]       fin_cmp;
		logic [POS_W-1:0] fin_pos;
		logic             greater;
		logic [1:0]       cnt;
		result_t          res0;
		result_t          res1;
		result_t          fin_err;
		logic             fin_has_err;

		phase_d     = phase_q;
		tag_d       = tag_q;
		acc_d       = acc_q;
		dcls_d      = dcls_q;
		rem_d       = rem_q;
		prev_len_d  = prev_len_q;
		have_prev_d = have_prev_q;
		pos_d       = pos_q;
		cmp_d       = cmp_q;
		err_d       = err_q;
		ram_we      = 1'b0;
		cnt         = 2'd0;
		res0        = '0;
		res1        = '0;
		fin_req     = 1'b0;
		fin_err     = '0;
		fin_has_err = 1'b0;

		// Decimal digit step: acc * 10 + d, with overflow seen in the top bits.
		is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
		acc10    = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {64'b0, data_byte[3:0]};
		term     = (phase_q == PH_INT) ? CH_SEMI : CH_COLON;
		dec_err  = 1'b0;
		dec_code = ERR_NON_DIGIT;
		dec_done = 1'b0;
		if (data_byte == term) begin
			if (dcls_q == DC_NONE) begin
				dec_err = 1'b1;
			end else begin
				dec_done = 1'b1;
			end
		end else if (!is_digit) begin
			dec_err = 1'b1;
		end else if (dcls_q == DC_ONE && acc_q == 64'd0) begin
			dec_err  = 1'b1;
			dec_code = ERR_LEADING_ZERO;
		end else if (|acc10[67:64]) begin
			dec_err  = 1'b1;
			dec_code = ERR_TOO_LARGE;
		end

		// Name comparison against the stored previous name, byte at pos_q.
		cmp_n = cmp_q;
		if (pos_q < MAX_POS && have_prev_q && cmp_q == CMP_EQ && pos_q < prev_len_q) begin
			if (data_byte < prev_byte) begin
				cmp_n = CMP_LESS;
			end else if (data_byte > prev_byte) begin
				cmp_n = CMP_GREATER;
			end
		end
		pos_n = pos_q + 1'b1;

		if (fire) begin
			if (end_marker) begin
				if (!err_q) begin
					cnt = 2'd1;
					if (phase_q == PH_TAG) begin
						res0 = make_res(EV_ACCEPT, 64'd0, 4'd0);
					end else if (phase_q == PH_NAME || phase_q == PH_SVAL) begin
						res0 = make_res(EV_ERROR, 64'd0, ERR_LENGTH_PAST);
					end else begin
						res0 = make_res(EV_ERROR, 64'd0, ERR_UNEXPECTED_END);
					end
				end
				phase_d     = PH_TAG;
				tag_d       = TAG_S;
				acc_d       = 64'd0;
				dcls_d      = DC_NONE;
				rem_d       = 64'd0;
				prev_len_d  = '0;
				have_prev_d = 1'b0;
				pos_d       = '0;
				cmp_d       = CMP_EQ;
				err_d       = 1'b0;
			end else if (!err_q) begin
				case (phase_q)
					PH_TAG: begin
						if (data_byte == CH_S) begin
							tag_d = TAG_S;
						end else if (data_byte == CH_I) begin
							tag_d = TAG_I;
						end else if (data_byte == CH_B) begin
							tag_d = TAG_B;
						end else begin
							tag_d = TAG_X;
						end
						phase_d = PH_NLEN;
						acc_d   = 64'd0;
						dcls_d  = DC_NONE;
					end
					PH_NLEN, PH_SLEN, PH_INT: begin
						if (dec_err) begin
							cnt   = 2'd1;
							res0  = make_res(EV_ERROR, 64'd0, dec_code);
							err_d = 1'b1;
						end else if (dec_done) begin
							if (phase_q == PH_NLEN) begin
								if (acc_q > MAX_LEN64) begin
									cnt   = 2'd1;
									res0  = make_res(EV_ERROR, 64'd0, ERR_NAME_TOO_LONG);
									err_d = 1'b1;
								end else begin
									rem_d = acc_q;
									pos_d = '0;
									cmp_d = CMP_EQ;
									if (acc_q == 64'd0) begin
										fin_req = 1'b1;
									end else begin
										phase_d = PH_NAME;
									end
								end
							end else if (phase_q == PH_SLEN) begin
								rem_d = acc_q;
								if (acc_q == 64'd0) begin
									cnt     = 2'd1;
									res0    = make_res(EV_COMPLETE, 64'd0, 4'd0);
									phase_d = PH_TAG;
								end else begin
									phase_d = PH_SVAL;
								end
							end else begin
								cnt     = 2'd2;
								res0    = make_res(EV_INTEGER, acc_q, 4'd0);
								res1    = make_res(EV_COMPLETE, 64'd0, 4'd0);
								phase_d = PH_TAG;
							end
						end else begin
							acc_d  = acc10[63:0];
							dcls_d = (dcls_q == DC_MORE) ? DC_MORE : dcls_q + 2'd1;
						end
					end
					PH_NAME: begin
						cnt  = 2'd1;
						res0 = make_res(EV_NAME, {56'd0, data_byte}, 4'd0);
						if (pos_q < MAX_POS) begin
							cmp_d  = cmp_n;
							ram_we = 1'b1;
						end
						pos_d = pos_n;
						rem_d = rem_q - 64'd1;
						if (rem_q == 64'd1) begin
							fin_req = 1'b1;
						end
					end
					PH_SVAL: begin
						cnt   = 2'd1;
						res0  = make_res(EV_STRING, {56'd0, data_byte}, 4'd0);
						rem_d = rem_q - 64'd1;
						if (rem_q == 64'd1) begin
							cnt     = 2'd2;
							res1    = make_res(EV_COMPLETE, 64'd0, 4'd0);
							phase_d = PH_TAG;
						end
					end
					PH_BOOL: begin
						if (data_byte == CH_ZERO || data_byte == CH_ONE) begin
							cnt     = 2'd2;
							res0    = make_res(EV_BOOLEAN, {63'd0, data_byte == CH_ONE}, 4'd0);
							res1    = make_res(EV_COMPLETE, 64'd0, 4'd0);
							phase_d = PH_TAG;
						end else begin
							cnt   = 2'd1;
							res0  = make_res(EV_ERROR, 64'd0, ERR_BAD_BOOLEAN);
							err_d = 1'b1;
						end
					end
					default: begin
						phase_d = PH_TAG;
					end
				endcase
			end
		end

		// The name has ended: check the order, then move on to the value the tag asks for, or flag a bad tag.
		fin_cmp = (phase_q == PH_NAME) ? cmp_n : CMP_EQ;
		fin_pos = (phase_q == PH_NAME) ? pos_n : '0;
		greater = (fin_cmp == CMP_GREATER) || (fin_cmp == CMP_EQ && fin_pos > prev_len_q);
		if (fin_req) begin
			if (have_prev_q && !greater) begin
				fin_has_err = 1'b1;
				fin_err     = make_res(EV_ERROR, 64'd0, ERR_ORDER);
			end else begin
				prev_len_d  = fin_pos;
				have_prev_d = 1'b1;
				case (tag_q)
					TAG_S: begin
						phase_d = PH_SLEN;
						acc_d   = 64'd0;
						dcls_d  = DC_NONE;
					end
					TAG_I: begin
						phase_d = PH_INT;
						acc_d   = 64'd0;
						dcls_d  = DC_NONE;
					end
					TAG_B: begin
						phase_d = PH_BOOL;
					end
					default: begin
						fin_has_err = 1'b1;
						fin_err     = make_res(EV_ERROR, 64'd0, ERR_BAD_TAG);
					end
				endcase
			end
			if (fin_has_err) begin
				err_d = 1'b1;
				if (cnt == 2'd0) begin
					res0 = fin_err;
					cnt  = 2'd1;
				end else begin
					res1 = fin_err;
					cnt  = 2'd2;
				end
			end
		end

		if (cnt == 2'd1) begin
			res0.last_result = 1'b1;
		end
		if (cnt == 2'd2) begin
			res1.last_result = 1'b1;
		end
		push.count  = cnt;
		push.first  = res0;
		push.second = res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TAG;
			tag_q       <= TAG_S;
			acc_q       <= 64'd0;
			dcls_q      <= DC_NONE;
			rem_q       <= 64'd0;
			prev_len_q  <= '0;
			have_prev_q <= 1'b0;
			pos_q       <= '0;
			cmp_q       <= CMP_EQ;
			err_q       <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			tag_q       <= tag_d;
			acc_q       <= acc_d;
			dcls_q      <= dcls_d;
			rem_q       <= rem_d;
			prev_len_q  <= prev_len_d;
			have_prev_q <= have_prev_d;
			pos_q       <= pos_d;
			cmp_q       <= cmp_d;
			err_q       <= err_d;
		end
	end

endmodule

### design/tlpap_outq.sv
// Four-entry result queue: takes up to two results a cycle and hands out one while out_stall is low.
// Depends on tlpap_pkg.
`timescale 1ns / 1ps
module tlpap_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  tlpap_pkg::push_t   push,
	output logic               room,
	output logic               out_valid,
	input  logic               out_stall,
	output tlpap_pkg::result_t head
);
	import tlpap_pkg::*;

	result_t    entry_q [4];
	logic [1:0] wptr_q;
	logic [1:0] rptr_q;
	logic [2:0] cnt_q;
	logic       pop;

	// Room for two results is kept so that any request can be taken.
	assign room      = (cnt_q <= 3'd2);
	assign out_valid = (cnt_q != 3'd0);
	assign head      = entry_q[rptr_q];
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entry_q[wptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			entry_q[wptr_q + 2'd1] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 2'd0;
			rptr_q <= 2'd0;
			cnt_q  <= 3'd0;
		end else begin
			wptr_q <= wptr_q + push.count;
			rptr_q <= rptr_q + {1'b0, pop};
			cnt_q  <= cnt_q + {1'b0, push.count} - {2'b0, pop};
		end
	end

endmodule

### design/tagged_length_prefixed_attr_parser.sv
// Top level of the tagged, length-prefixed attribute parser.
// Depends on tlpap_pkg, tlpap_core (with tlpap_ram) and tlpap_outq.
//
//   channel | handshake            | fields
//   input   | in_valid / in_stall  | data_byte, end_marker
//   output  | out_valid/ out_stall | event_res, payload, error_code, last_result
//
// One request is taken per cycle while in_stall is low; its results enter the queue at
// that edge and, if the queue was empty, the first is offered on the next cycle. The rate
// is set by the output side: each result needs its own output cycle, and the queue holds
// up to four results. in_stall rises when fewer than two queue entries are free. Reset
// clears the parser state and the queue at once; the name buffer needs no clearing.
`timescale 1ns / 1ps
module tagged_length_prefixed_attr_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_marker,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_res,
	output logic [63:0] payload,
	output logic [3:0]  error_code,
	output logic        last_result
);
	import tlpap_pkg::*;

	push_t   push;
	result_t head;
	logic    room;
	logic    fire;

	assign in_stall = !room;
	assign fire     = in_valid && room;

	tlpap_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.data_byte (data_byte),
		.end_marker(end_marker),
		.push      (push)
	);

	tlpap_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.head     (head)
	);

	assign event_res   = head.event_res;
	assign payload     = head.payload;
	assign error_code  = head.error_code;
	assign last_result = head.last_result;

endmodule

### design/tlpap_checker.sv
// Port-level checker for the attribute parser, bound to the top level.
// Depends on tlpap_pkg and tagged_length_prefixed_attr_parser.
`timescale 1ns / 1ps
module tlpap_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  event_res,
	input logic [63:0] payload,
	input logic [3:0]  error_code,
	input logic        last_result
);
	import tlpap_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_res) && $stable(payload))
		else $error("stalled result changed");

	a_code_only_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EV_ERROR |-> error_code == 4'd0)
		else $error("error code on a non-error result");

	a_empty_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == EV_COMPLETE || event_res == EV_ACCEPT ||
		event_res == EV_ERROR) |-> payload == 64'd0)
		else $error("payload on a result that carries none");

	a_bool_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == EV_BOOLEAN || event_res == EV_NAME ||
		event_res == EV_STRING) |-> payload[63:8] == 56'd0)
		else $error("byte or boolean payload too wide");

	a_final_results: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == EV_ACCEPT || event_res == EV_ERROR ||
		event_res == EV_COMPLETE) |-> last_result)
		else $error("closing result not marked as last");

endmodule

bind tagged_length_prefixed_attr_parser tlpap_checker u_tlpap_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.event_res  (event_res),
	.payload    (payload),
	.error_code (error_code),
	.last_result(last_result)
);
